// ===== rtl/imw_pkg.sv =====
// Package for the in-flight message window: sizes, codes and the
// record types shared by the front stage, the command queue and the engine.
// Depends on nothing.
package imw_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SIZE_W = 20;
	localparam int ID_W = 16;
	localparam int HANDLE_W = 16;
	localparam int COUNT_OUT_W = 5;

	localparam logic [1:0] CMD_TRACK = 2'd0;
	localparam logic [1:0] CMD_ACK = 2'd1;
	localparam logic [1:0] CMD_WALK = 2'd2;

	localparam logic [1:0] LINK_NOT_LINKED = 2'd1;
	localparam logic [1:0] LINK_LINKED = 2'd2;

	localparam logic [SIZE_W-1:0] BUDGET_RESET = 20'd16384;

	typedef enum logic [1:0] {
		OP_TRACK,
		OP_ACK,
		OP_WALK
	} op_t;

	typedef enum logic [2:0] {
		KIND_STORED,
		KIND_EVICTED,
		KIND_ACKED,
		KIND_UNMATCHED,
		KIND_RESEND,
		KIND_DROPPED,
		KIND_EMPTY
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRACK,
		ST_ACK,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic                scope;
		logic [1:0]          qos;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t ent;
		logic   ok_dev;
		logic   ok_ses;
	} cmd_t;

endpackage

// ===== rtl/imw_front.sv =====
// Front stage of the in-flight message window: takes input transfers,
// decodes the command and the link status and hands a command record on.
// Depends on imw_pkg.
module imw_front import imw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        push_ready
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic [1:0] link;

	assign s_tready = !valid_s1 || push_ready;
	assign push = valid_s1;
	assign push_cmd = cmd_s1;
	assign link = s_tdata[56:55];

	always_comb begin
		dec.ent.id = s_tdata[15:0];
		dec.ent.scope = s_tdata[16];
		dec.ent.qos = s_tdata[18:17];
		dec.ent.size = s_tdata[38:19];
		dec.ent.handle = s_tdata[54:39];
		dec.ok_ses = (link == LINK_LINKED);
		dec.ok_dev = (link == LINK_LINKED) || (link == LINK_NOT_LINKED);
		case (s_tuser)
			CMD_TRACK: dec.op = OP_TRACK;
			CMD_ACK: dec.op = OP_ACK;
			default: dec.op = OP_WALK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && (s_tuser inside {CMD_TRACK, CMD_ACK, CMD_WALK});
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// ===== rtl/imw_queue.sv =====
// Two-entry command queue between the front stage and the window engine.
// Depends on imw_pkg.
module imw_queue import imw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_cmd = slot_q[rd_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/imw_engine.sv =====
// Window engine: holds the age-ordered entry table, the counters and the
// byte budget, and carries out track, ack and retransmit one command at a time.
// Depends on imw_pkg.
module imw_engine import imw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [79:0]       m_tdata,
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);

	entry_t            table_q [WINDOW_DEPTH];
	state_t            state_q;
	state_t            state_d;
	cmd_t              cur_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  i_q;
	logic [SIZE_W-1:0] bt_q;
	logic [SIZE_W-1:0] budget_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	entry_t            out_ent_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [SIZE_W-1:0] out_bytes_q;
	logic              out_last_q;

	entry_t            head;
	entry_t            sel;
	entry_t            zero_ent;
	logic              can_emit;
	logic              evict;
	logic              ok;
	logic              emit;
	kind_t             res_kind;
	entry_t            res_ent;
	logic [CNT_W-1:0]  res_cnt;
	logic [SIZE_W-1:0] res_bytes;
	logic              res_last;
	logic              do_remove;
	logic [IDX_W-1:0]  rm_idx;
	logic              do_append;
	logic              i_inc;

	assign head = table_q[0];
	assign sel = table_q[i_q[IDX_W-1:0]];
	assign can_emit = !out_valid_q || m_tready;
	assign evict = (cnt_q >= CNT_W'(WINDOW_DEPTH)) ||
		((cnt_q != '0) && (({1'b0, bt_q} + {1'b0, cur_q.ent.size}) > {1'b0, budget_q}));
	assign ok = sel.scope ? cur_q.ok_ses : cur_q.ok_dev;

	always_comb begin
		zero_ent = '0;
		q_pop = 1'b0;
		emit = 1'b0;
		res_kind = KIND_STORED;
		res_ent = zero_ent;
		res_cnt = cnt_q;
		res_bytes = bt_q;
		res_last = 1'b0;
		do_remove = 1'b0;
		rm_idx = i_q[IDX_W-1:0];
		do_append = 1'b0;
		i_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
			end
			ST_TRACK: begin
				if (can_emit) begin
					emit = 1'b1;
					if (evict) begin
						res_kind = KIND_EVICTED;
						res_ent = head;
						res_cnt = cnt_q - CNT_W'(1);
						res_bytes = bt_q - head.size;
						do_remove = 1'b1;
						rm_idx = '0;
					end else begin
						res_kind = KIND_STORED;
						res_ent = cur_q.ent;
						res_cnt = cnt_q + CNT_W'(1);
						res_bytes = bt_q + cur_q.ent.size;
						res_last = 1'b1;
						do_append = 1'b1;
					end
				end
			end
			ST_ACK: begin
				if (i_q == cnt_q) begin
					emit = can_emit;
					res_kind = KIND_UNMATCHED;
					res_ent.id = cur_q.ent.id;
					res_last = 1'b1;
				end else if (sel.id == cur_q.ent.id) begin
					emit = can_emit;
					do_remove = can_emit;
					res_kind = KIND_ACKED;
					res_ent = sel;
					res_cnt = cnt_q - CNT_W'(1);
					res_bytes = bt_q - sel.size;
					res_last = 1'b1;
				end else begin
					i_inc = 1'b1;
				end
			end
			ST_WALK: begin
				if (cnt_q == '0) begin
					emit = can_emit;
					res_kind = KIND_EMPTY;
					res_last = 1'b1;
				end else if (can_emit) begin
					emit = 1'b1;
					res_ent = sel;
					if (!ok) begin
						res_kind = KIND_DROPPED;
						do_remove = 1'b1;
						res_cnt = cnt_q - CNT_W'(1);
						res_bytes = bt_q - sel.size;
						res_last = (i_q == cnt_q - CNT_W'(1));
					end else begin
						res_kind = KIND_RESEND;
						i_inc = 1'b1;
						res_last = (i_q + CNT_W'(1) == cnt_q);
					end
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_TRACK: state_d = ST_TRACK;
						OP_ACK: state_d = ST_ACK;
						default: state_d = ST_WALK;
					endcase
				end
			end
			default: begin
				if (emit && res_last) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			bt_q <= '0;
			i_q <= '0;
			budget_q <= BUDGET_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			if (do_remove || do_append) begin
				cnt_q <= res_cnt;
				bt_q <= res_bytes;
			end
			if (q_pop) begin
				i_q <= '0;
			end else if (i_inc) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (emit) begin
			out_kind_q <= res_kind;
			out_ent_q <= res_ent;
			out_cnt_q <= res_cnt;
			out_bytes_q <= res_bytes;
			out_last_q <= res_last;
		end
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			if (do_remove && (IDX_W'(j) >= rm_idx) && (j < WINDOW_DEPTH - 1)) begin
				table_q[j] <= table_q[(j + 1) % WINDOW_DEPTH];
			end else if (do_append && (IDX_W'(j) == cnt_q[IDX_W-1:0])) begin
				table_q[j] <= cur_q.ent;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {out_bytes_q, COUNT_OUT_W'(out_cnt_q), out_ent_q.handle,
		out_ent_q.size, out_ent_q.qos, out_ent_q.scope, out_ent_q.id};

endmodule

// ===== rtl/inflight_message_window.sv =====
// Top level of the in-flight message window: front stage, command queue
// and window engine joined together.
// Depends on imw_pkg, imw_front, imw_queue and imw_engine.
//
// The slave stream carries commands: track a new message, acknowledge by id,
// or walk the window for retransmission; command code three is taken and
// ignored. Each command yields one or more result transfers on the master
// stream, and tlast marks the final result of a command. The byte budget is
// written through cfg_we and cfg_wdata; the user must write it only while the
// block is idle, which the block does not enforce. A command passes the front
// register, a queue slot and the engine's command register before its first
// result is registered. A track emits one result per evicted entry, then the
// stored entry; an ack searches at most 16 entries and ends in an acked or
// unmatched result; a walk emits one result per entry, or one empty result.
// The engine reads one table entry a cycle unless the receiver stalls. A
// two-entry queue lets new commands be taken while the engine works. Reset
// empties the window, clears the byte count and loads a budget of 16384
// bytes. When the receiver stalls, the result register holds its transfer
// and the engine waits; the front fills the queue and then its own register.
module inflight_message_window import imw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// msg_id[15:0], scope[16], qos[18:17], payload_len[38:19],
	// buffer_handle[54:39], link_status[56:55], zero above.
	input  logic [63:0] s_tdata,
	// command[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// msg_id_res[15:0], scope_res[16], qos_res[18:17], payload_len_res[38:19],
	// buffer_handle_res[54:39], entry_count[59:55], bytes_in_flight[79:60].
	output logic [79:0] m_tdata,
	// kind[2:0].
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	logic push;
	cmd_t push_cmd;
	logic push_ready;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	imw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	imw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd),
		.pop        (q_pop)
	);

	imw_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
